>>> src/rfs_pkg.sv
// rfs_pkg: shared types, constants and helpers for the random flash scheduler.
// Used by rfs_ctrl, rfs_datapath and random_flash_scheduler; no dependencies.
package rfs_pkg;

    // Default sizing
    localparam int FLASH_CHANNELS_DEF = 6;
    localparam int MAX_TRIES_DEF      = 25;

    // Register map
    localparam int                  APB_AW        = 2;
    localparam int                  APB_DW        = 32;
    localparam logic [APB_AW-1:0]   ADDR_RNG_SEED = 2'd0;

    // Random source
    localparam logic [15:0] SEED_RESET = 16'd44257;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    // Timing and knob constants
    localparam int          LEN_BASE    = 50;
    localparam int          LEN_RANGE   = 100;
    localparam logic [7:0]  POT_LIMIT   = 8'd230;
    localparam int          PAUSE_SHIFT = 10;
    localparam int          PAUSE_MULT  = 20;
    localparam int          POT_FULL    = 255;

    // Scheduler phase, also shown on phase_code
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PICK  = 2'd1,
        PH_FLASH = 2'd2,
        PH_OVER  = 2'd3
    } t_phase;

    // Controller states
    typedef enum logic [2:0] {
        ST_READY,
        ST_EVAL,
        ST_DRAW,
        ST_CHECK,
        ST_LDRAW,
        ST_LSET,
        ST_DONE
    } t_ctrl_state;

    // Input and result payloads
    typedef struct packed {
        logic [31:0] now_ms;
        logic [7:0]  flash_pot;
    } t_in;

    typedef struct packed {
        logic [2:0] flash_channel;
        logic       is_flashing;
        logic       mode_lamp;
        logic [1:0] phase_code;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the accepted transaction
        logic eval;      // single-step update for idle, flashing and over
        logic draw;      // advance LFSR and start the reciprocal multiply
        logic draw_len;  // draw is for the flash length, not a channel
        logic take_ch;   // drawn channel is free: claim it
        logic miss;      // all draws missed: go to over
        logic set_len;   // load flash length and enter flashing
        logic out_load;  // capture the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_phase phase;
        logic   ch_free;
    } t_dp_stat;

    // Pause in seconds from the knob: pot*20/255, with x/255 as (x + (x >> 8) + 1) >> 8
    function automatic logic [4:0] pause_from_pot(input logic [7:0] pot);
        logic [12:0] scaled;
        logic [13:0] sum;
        scaled = 13'(pot) * 13'(PAUSE_MULT);
        sum    = 14'(scaled) + 14'(scaled >> 8) + 14'd1;
        return 5'(sum >> 8);
    endfunction

endpackage

>>> src/random_flash_scheduler.sv
// random_flash_scheduler: top level with the APB seed register.
// Instantiates rfs_ctrl and rfs_datapath; uses rfs_pkg.
// A transaction goes through ready and eval, then done with no draw (idle, flashing, over).
// Pick adds a draw and a check per try until a channel is free (then a length draw and
// the length set) or all MAX_TRIES draws miss. Input stalls until the result is loaded.
// Each draw is an LFSR step with a reciprocal multiply, then a remainder step.
// Reset is synchronous, active low: phase idle, all channels free, seed 44257.
module random_flash_scheduler #(
    parameter int FLASH_CHANNELS = rfs_pkg::FLASH_CHANNELS_DEF,
    parameter int MAX_TRIES      = rfs_pkg::MAX_TRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  rfs_pkg::t_in                 i_in_data,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output rfs_pkg::t_out                o_out_data,
    input  logic                         i_out_stall,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rfs_pkg::APB_AW-1:0]   paddr,
    input  logic [rfs_pkg::APB_DW-1:0]   pwdata,
    output logic [rfs_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import rfs_pkg::*;

    logic [15:0]  r_rng_seed;
    logic         w_seed_wr;
    t_dp_cmd      w_cmd;
    t_dp_stat     w_stat;

    // APB access to the seed register
    assign pready    = 1'b1;
    assign w_seed_wr = psel && penable && pwrite && (paddr == ADDR_RNG_SEED);
    assign prdata    = (paddr == ADDR_RNG_SEED) ? {16'd0, r_rng_seed} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng_seed <= SEED_RESET;
        end else if (w_seed_wr) begin
            r_rng_seed <= pwdata[15:0];
        end
    end

    rfs_ctrl #(
        .MAX_TRIES (MAX_TRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rfs_datapath #(
        .FLASH_CHANNELS (FLASH_CHANNELS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_seed_load  (w_seed_wr),
        .i_seed_value (pwdata[15:0]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_data   (o_out_data)
    );

endmodule

>>> src/rfs_ctrl.sv
// rfs_ctrl: sequencer for the random flash scheduler.
// Drives rfs_datapath through t_dp_cmd and owns both handshakes; uses rfs_pkg.
module rfs_ctrl #(
    parameter int MAX_TRIES = rfs_pkg::MAX_TRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  rfs_pkg::t_dp_stat  i_stat,
    output rfs_pkg::t_dp_cmd   o_cmd
);
    import rfs_pkg::*;

    localparam int TryW = $clog2(MAX_TRIES + 1);

    t_ctrl_state       r_state, n_state;
    logic [TryW-1:0]   r_tries, n_tries;
    logic              r_out_valid, n_out_valid;
    logic              w_last_try;
    logic              w_out_free;
    logic              w_in_accept;

    assign w_last_try  = (r_tries == TryW'(MAX_TRIES - 1));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_in_accept = i_in_valid && (r_state == ST_READY);
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_READY: begin
                if (i_in_valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_stat.phase == PH_PICK) n_state = ST_DRAW;
                else                         n_state = ST_DONE;
            end
            ST_DRAW:  n_state = ST_CHECK;
            ST_CHECK: begin
                priority if (i_stat.ch_free) n_state = ST_LDRAW;
                else if (w_last_try)         n_state = ST_DONE;
                else                         n_state = ST_DRAW;
            end
            ST_LDRAW: n_state = ST_LSET;
            ST_LSET:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) n_state = ST_READY;
            end
            default:  n_state = ST_READY;
        endcase
    end

    // Commands and input stall
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_READY: begin
                o_in_stall = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            ST_EVAL:  o_cmd.eval = (i_stat.phase != PH_PICK);
            ST_DRAW:  o_cmd.draw = 1'b1;
            ST_CHECK: begin
                o_cmd.take_ch = i_stat.ch_free;
                o_cmd.miss    = !i_stat.ch_free && w_last_try;
            end
            ST_LDRAW: begin
                o_cmd.draw     = 1'b1;
                o_cmd.draw_len = 1'b1;
            end
            ST_LSET:  o_cmd.set_len  = 1'b1;
            ST_DONE:  o_cmd.out_load = w_out_free;
            default:  o_cmd = '0;
        endcase
    end

    // Draw counter and result valid
    always_comb begin
        n_tries = r_tries;
        if (r_state == ST_EVAL) begin
            n_tries = '0;
        end else if (r_state == ST_CHECK && !i_stat.ch_free && !w_last_try) begin
            n_tries = r_tries + 1'b1;
        end
        n_out_valid = o_cmd.out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_tries     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tries     <= n_tries;
            r_out_valid <= n_out_valid;
        end
    end

    // Draw counter never passes the try budget
    a_tries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tries < TryW'(MAX_TRIES))
        else $error("draw counter beyond try budget");

    // An accepted transaction is evaluated on the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ST_EVAL))
        else $error("accepted transaction not evaluated");

    // A check always follows its draw
    a_check_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> ($past(r_state) == ST_DRAW))
        else $error("check without draw");

endmodule

>>> src/rfs_datapath.sv
// rfs_datapath: scheduler state, LFSR, reciprocal modulo unit and result register.
// Driven by rfs_ctrl commands; uses rfs_pkg.
module rfs_datapath #(
    parameter int FLASH_CHANNELS = rfs_pkg::FLASH_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfs_pkg::t_in       i_in_data,
    input  logic               i_seed_load,
    input  logic [15:0]        i_seed_value,
    input  rfs_pkg::t_dp_cmd   i_cmd,
    output rfs_pkg::t_dp_stat  o_stat,
    output rfs_pkg::t_out      o_out_data
);
    import rfs_pkg::*;

    localparam int ChW = (FLASH_CHANNELS > 1) ? $clog2(FLASH_CHANNELS) : 1;

    // Reciprocal constants: floor(x/N) = (x*M) >> S is exact for 16-bit x
    localparam int          ShCh   = 16 + $clog2(FLASH_CHANNELS);
    localparam int          ShLen  = 16 + $clog2(LEN_RANGE);
    localparam logic [16:0] MulCh  =
        17'(((64'd1 << ShCh) + 64'(FLASH_CHANNELS) - 64'd1) / 64'(FLASH_CHANNELS));
    localparam logic [16:0] MulLen =
        17'(((64'd1 << ShLen) + 64'(LEN_RANGE) - 64'd1) / 64'(LEN_RANGE));

    // Scheduler state
    t_phase                      r_phase, n_phase;
    logic [FLASH_CHANNELS-1:0]   r_free_mask, n_free_mask;
    logic [31:0]                 r_pause_start, n_pause_start;
    logic [31:0]                 r_flash_begin, n_flash_begin;
    logic [7:0]                  r_flash_length, n_flash_length;
    logic [4:0]                  r_pause_seconds, n_pause_seconds;
    logic [ChW-1:0]              r_cur_ch, n_cur_ch;
    logic [15:0]                 r_lfsr, n_lfsr;

    // Transaction and arithmetic registers
    logic [31:0]                 r_now;
    logic [7:0]                  r_pot;
    logic [32:0]                 r_prod;
    logic                        r_len;
    t_out                        r_out;

    logic [15:0]                 w_lfsr_next;
    logic [16:0]                 w_mult;
    logic [15:0]                 w_quot;
    logic [6:0]                  w_range;
    logic [22:0]                 w_diff;
    logic [15:0]                 w_rem;
    logic [ChW-1:0]              w_rem_ch;
    logic                        w_pause_done;
    logic                        w_flash_done;

    // LFSR step, Galois form shifting right
    assign w_lfsr_next = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);
    assign w_mult      = i_cmd.draw_len ? MulLen : MulCh;

    // Remainder from the registered product, with one correction step
    assign w_range  = r_len ? 7'(LEN_RANGE) : 7'(FLASH_CHANNELS);
    assign w_quot   = r_len ? 16'(r_prod >> ShLen) : 16'(r_prod >> ShCh);
    assign w_diff   = 23'(r_lfsr) - (23'(w_quot) * 23'(w_range));
    assign w_rem    = (w_diff[15:0] >= 16'(w_range)) ? (w_diff[15:0] - 16'(w_range))
                                                     : w_diff[15:0];
    assign w_rem_ch = w_rem[ChW-1:0];

    // Timers, modulo 2^32
    assign w_pause_done = (r_now - r_pause_start) >
                          {17'd0, r_pause_seconds, PAUSE_SHIFT'(0)};
    assign w_flash_done = (r_now - r_flash_begin) > {24'd0, r_flash_length};

    assign o_stat.phase   = r_phase;
    assign o_stat.ch_free = r_free_mask[w_rem_ch];
    assign o_out_data     = r_out;

    // Next scheduler state
    always_comb begin
        n_phase         = r_phase;
        n_free_mask     = r_free_mask;
        n_pause_start   = r_pause_start;
        n_flash_begin   = r_flash_begin;
        n_flash_length  = r_flash_length;
        n_pause_seconds = r_pause_seconds;
        n_cur_ch        = r_cur_ch;
        n_lfsr          = r_lfsr;

        if (i_cmd.eval) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (w_pause_done && (r_pot < POT_LIMIT)) n_phase = PH_PICK;
                    n_cur_ch = '0;
                end
                PH_PICK: begin
                end
                PH_FLASH: begin
                    if (w_flash_done) n_phase = PH_PICK;
                end
                PH_OVER: begin
                    n_free_mask     = '1;
                    n_cur_ch        = '0;
                    n_pause_start   = r_now;
                    n_pause_seconds = pause_from_pot(r_pot);
                    n_phase         = PH_IDLE;
                end
            endcase
        end

        // Claim the drawn channel
        if (i_cmd.take_ch) begin
            n_free_mask[w_rem_ch] = 1'b0;
            n_cur_ch              = w_rem_ch;
        end

        if (i_cmd.set_len) begin
            n_flash_length = 8'(LEN_BASE) + w_rem[7:0];
            n_flash_begin  = r_now;
            n_phase        = PH_FLASH;
        end

        if (i_cmd.miss) n_phase = PH_OVER;

        // Seed write reloads the LFSR; zero would lock it
        if (i_seed_load) begin
            n_lfsr = (i_seed_value == 16'd0) ? SEED_RESET : i_seed_value;
        end else if (i_cmd.draw) begin
            n_lfsr = w_lfsr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_free_mask     <= '1;
            r_pause_start   <= '0;
            r_flash_begin   <= '0;
            r_flash_length  <= '0;
            r_pause_seconds <= '0;
            r_cur_ch        <= '0;
            r_lfsr          <= SEED_RESET;
        end else begin
            r_phase         <= n_phase;
            r_free_mask     <= n_free_mask;
            r_pause_start   <= n_pause_start;
            r_flash_begin   <= n_flash_begin;
            r_flash_length  <= n_flash_length;
            r_pause_seconds <= n_pause_seconds;
            r_cur_ch        <= n_cur_ch;
            r_lfsr          <= n_lfsr;
        end
    end

    // Transaction capture, multiply stage and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_now <= i_in_data.now_ms;
            r_pot <= i_in_data.flash_pot;
        end
        if (i_cmd.draw) begin
            r_prod <= 33'(w_lfsr_next) * 33'(w_mult);
            r_len  <= i_cmd.draw_len;
        end
        if (i_cmd.out_load) begin
            r_out.flash_channel <= 3'(r_cur_ch);
            r_out.is_flashing   <= (r_phase == PH_FLASH);
            r_out.mode_lamp     <= (r_pot <= POT_LIMIT);
            r_out.phase_code    <= r_phase;
        end
    end

    // Remainder is in range whenever it is used
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_ch || i_cmd.set_len) |-> (w_rem < 16'(w_range)))
        else $error("remainder out of range");

    // Flash length lands in its window and flashing starts
    a_len_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_len |=> (r_phase == PH_FLASH &&
                           r_flash_length >= 8'(LEN_BASE) &&
                           r_flash_length <  8'(LEN_BASE + LEN_RANGE)))
        else $error("flash length outside window");

    // A claimed channel becomes current and is no longer free
    a_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_ch |=> (!r_free_mask[$past(w_rem_ch)] &&
                           r_cur_ch == $past(w_rem_ch)))
        else $error("channel claim not recorded");

endmodule
